>>> rtl/lerf_pkg.sv
// Shared types and constants for the lossy event ring FIFO.
// No dependencies; imported by lerf_ctrl and lossy_event_ring_fifo.
package lerf_pkg;

    // Field widths
    localparam int BUS_W    = 8;
    localparam int ACTION_W = 8;
    localparam int HDEPTH_W = 8;
    localparam int HPORT_W  = 8;
    localparam int SLOT_W   = 16;
    localparam int SEQ_W    = 48;
    localparam int STAMP_W  = 48;
    localparam int DROP_W   = 16;
    localparam int LIMIT_W  = 5;

    // Most entries one drain may pop
    localparam logic [LIMIT_W-1:0] MAX_DRAIN = LIMIT_W'(16);

    // Stream widths
    localparam int IN_DATA_W  = 104;
    localparam int OUT_DATA_W = 160;

    // Command codes carried on the input tuser
    localparam logic CMD_POST  = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    // One stored ring entry
    typedef struct packed {
        logic [STAMP_W-1:0]  stamp_ms;
        logic [SEQ_W-1:0]    seq;
        logic [SLOT_W-1:0]   slot;
        logic [HPORT_W-1:0]  hub_link;
        logic [HDEPTH_W-1:0] hub_tier;
        logic [ACTION_W-1:0] action;
        logic [BUS_W-1:0]    bus;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // Sideband for one result word, from the sequencer to the output stage
    typedef struct packed {
        logic              issue;
        logic              empty_res;
        logic              last;
        logic [DROP_W-1:0] dropped;
    } pop_info_t;

endpackage

>>> rtl/lerf_ram.sv
// Simple dual-port synchronous RAM, one write and one read port,
// registered read data held while no read is issued. No dependencies.
module lerf_ram #(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int WIDTH = 144
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/lerf_ctrl.sv
// Ring sequencer: head, fill count, sequence number and drop counter,
// plus the drain state machine that issues RAM reads. Uses lerf_pkg.
module lerf_ctrl #(
    parameter int RING_DEPTH = 16,
    parameter int AW         = 4,
    parameter int CW         = 5
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        command,
    input  logic [lerf_pkg::LIMIT_W-1:0] drain_limit,
    input  logic                        slot_free,
    output logic                        mem_we,
    output logic [AW-1:0]               mem_waddr,
    output logic [lerf_pkg::SEQ_W-1:0]  post_seq,
    output logic                        mem_re,
    output logic [AW-1:0]               mem_raddr,
    output lerf_pkg::pop_info_t         pop
);
    import lerf_pkg::*;

    localparam int NW = (CW > LIMIT_W) ? CW : LIMIT_W;
    localparam int SW = AW + 1;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_DRAIN = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    logic [1:0]         state_reg, state_next;
    logic [AW-1:0]      head_reg, head_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [SEQ_W-1:0]   seq_reg, seq_next;
    logic [DROP_W-1:0]  drop_reg, drop_next;
    logic [LIMIT_W-1:0] remain_reg, remain_next;
    logic               first_reg, first_next;

    logic               full;
    logic [AW-1:0]      head_inc;
    logic [SW-1:0]      tail_sum;
    logic [AW-1:0]      tail_idx;
    logic [LIMIT_W-1:0] limit_sat;
    logic [NW-1:0]      pop_n;

    // Pointer arithmetic
    assign full     = (count_reg == CW'(RING_DEPTH));
    assign head_inc = (head_reg == AW'(RING_DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign tail_sum = SW'(head_reg) + SW'(count_reg);
    assign tail_idx = (tail_sum >= SW'(RING_DEPTH)) ? AW'(tail_sum - SW'(RING_DEPTH))
                                                    : AW'(tail_sum);

    // Entries this drain pops: min(saturated limit, fill count)
    assign limit_sat = (drain_limit > MAX_DRAIN) ? MAX_DRAIN : drain_limit;
    assign pop_n     = (NW'(limit_sat) < NW'(count_reg)) ? NW'(limit_sat) : NW'(count_reg);

    assign post_seq  = seq_reg;
    assign mem_raddr = head_reg;

    // Sequencer
    always_comb
    begin
        state_next  = state_reg;
        head_next   = head_reg;
        count_next  = count_reg;
        seq_next    = seq_reg;
        drop_next   = drop_reg;
        remain_next = remain_reg;
        first_next  = first_reg;
        in_ready    = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = tail_idx;
        mem_re      = 1'b0;
        pop         = '0;

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (command == CMD_POST)
                    begin
                        mem_we   = 1'b1;
                        seq_next = seq_reg + 1'b1;
                        if (full)
                        begin
                            // overwrite oldest entry
                            mem_waddr = head_reg;
                            head_next = head_inc;
                            drop_next = drop_reg + 1'b1;
                        end
                        else
                        begin
                            count_next = count_reg + 1'b1;
                        end
                    end
                    else if (pop_n == '0)
                    begin
                        state_next = ST_EMPTY;
                    end
                    else
                    begin
                        remain_next = LIMIT_W'(pop_n);
                        first_next  = 1'b1;
                        state_next  = ST_DRAIN;
                    end
                end
            end

            ST_DRAIN:
            begin
                if (slot_free)
                begin
                    mem_re      = 1'b1;
                    head_next   = head_inc;
                    count_next  = count_reg - 1'b1;
                    remain_next = remain_reg - 1'b1;
                    first_next  = 1'b0;
                    pop.issue   = 1'b1;
                    pop.last    = (remain_reg == LIMIT_W'(1));
                    if (first_reg)
                    begin
                        pop.dropped = drop_reg;
                        drop_next   = '0;
                    end
                    if (remain_reg == LIMIT_W'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            ST_EMPTY:
            begin
                if (slot_free)
                begin
                    pop.issue     = 1'b1;
                    pop.empty_res = 1'b1;
                    pop.last      = 1'b1;
                    state_next    = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            head_reg   <= '0;
            count_reg  <= '0;
            seq_reg    <= '0;
            drop_reg   <= '0;
            remain_reg <= '0;
            first_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            head_reg   <= head_next;
            count_reg  <= count_next;
            seq_reg    <= seq_next;
            drop_reg   <= drop_next;
            remain_reg <= remain_next;
            first_reg  <= first_next;
        end
    end

endmodule

>>> rtl/lossy_event_ring_fifo.sv
// Lossy event ring FIFO top level: stream ports, ring RAM, sequencer
// and the output stage. Uses lerf_pkg, lerf_ram and lerf_ctrl.
//
// Usage:
//   Input words arrive on s_axis_*. tuser selects post or drain. A post
//   stores one device event, stamped with a running 48-bit sequence number
//   and now_ms; on a full ring the oldest entry is overwritten and a
//   16-bit drop counter counts up. Posts may follow each other in every
//   cycle. A drain pops up to min(drain_limit, 16) of the oldest entries
//   on m_axis_*, tlast on the final word, the pending drop count on the
//   first word. A drain with nothing to pop gives one word with tuser set
//   and all data zero. A drain is registered into the sequencer state,
//   which then issues the RAM reads; words leave at one per cycle while
//   m_axis_tready is high, and the input is held until the final read
//   is issued.
//   The next item is taken while the last result word still waits.
//   Stalls: the RAM read register doubles as the output register and
//   holds its word until taken; no reads are issued meanwhile.
//   Reset: ring empty, sequence and drop counters zero, no output valid.
//   Ring contents are not cleared; only written entries are ever read.
module lossy_event_ring_fifo #(
    parameter int RING_DEPTH = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [7:0] bus_number, [15:8] event_action, [23:16] hub tier,
    // [31:24] hub link, [47:32] device_slot, [95:48] now_ms,
    // [100:96] drain_limit, [103:101] zero
    input  logic [lerf_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // [0] command
    input  logic [0:0]                      s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [7:0] out_bus, [15:8] out_action, [23:16] popped hub tier,
    // [31:24] popped hub link, [47:32] out_slot, [95:48] event_seq,
    // [143:96] event_time_ms, [159:144] dropped_count
    output logic [lerf_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // [0] empty_res
    output logic [0:0]                      m_axis_tuser,
    output logic                            m_axis_tlast
);
    import lerf_pkg::*;

    localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CW = $clog2(RING_DEPTH + 1);

    logic              slot_free;
    logic              mem_we;
    logic              mem_re;
    logic [AW-1:0]     mem_waddr;
    logic [AW-1:0]     mem_raddr;
    logic [SEQ_W-1:0]  post_seq;
    entry_t            wr_entry;
    logic [ENTRY_W-1:0] rd_bits;
    entry_t            rd_entry;
    pop_info_t         pop;

    logic              out_valid_reg;
    logic              out_empty_reg;
    logic              out_last_reg;
    logic [DROP_W-1:0] out_drop_reg;

    // Unpack the posted event into a ring entry
    always_comb
    begin
        wr_entry.bus      = s_axis_tdata[7:0];
        wr_entry.action   = s_axis_tdata[15:8];
        wr_entry.hub_tier = s_axis_tdata[23:16];
        wr_entry.hub_link = s_axis_tdata[31:24];
        wr_entry.slot     = s_axis_tdata[47:32];
        wr_entry.stamp_ms = s_axis_tdata[95:48];
        wr_entry.seq      = post_seq;
    end

    lerf_ctrl #(
        .RING_DEPTH (RING_DEPTH),
        .AW         (AW),
        .CW         (CW)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .command     (s_axis_tuser[0]),
        .drain_limit (s_axis_tdata[100:96]),
        .slot_free   (slot_free),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .post_seq    (post_seq),
        .mem_re      (mem_re),
        .mem_raddr   (mem_raddr),
        .pop         (pop)
    );

    lerf_ram #(
        .DEPTH (RING_DEPTH),
        .AW    (AW),
        .WIDTH (ENTRY_W)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (wr_entry),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (rd_bits)
    );

    // Output stage: a new word may enter when empty or being taken
    assign slot_free = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (pop.issue)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Sideband of the word in flight; payload sits in the RAM read register
    always_ff @(posedge clk)
    begin
        if (pop.issue)
        begin
            out_empty_reg <= pop.empty_res;
            out_last_reg  <= pop.last;
            out_drop_reg  <= pop.dropped;
        end
    end

    // Pack the result word; an empty drain shows all-zero data
    assign rd_entry = rd_bits;

    always_comb
    begin
        m_axis_tdata = '0;
        if (!out_empty_reg)
        begin
            m_axis_tdata[7:0]     = rd_entry.bus;
            m_axis_tdata[15:8]    = rd_entry.action;
            m_axis_tdata[23:16]   = rd_entry.hub_tier;
            m_axis_tdata[31:24]   = rd_entry.hub_link;
            m_axis_tdata[47:32]   = rd_entry.slot;
            m_axis_tdata[95:48]   = rd_entry.seq;
            m_axis_tdata[143:96]  = rd_entry.stamp_ms;
            m_axis_tdata[159:144] = out_drop_reg;
        end
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tuser[0] = out_empty_reg;
    assign m_axis_tlast    = out_last_reg;

endmodule

>>> verif/lossy_event_ring_fifo_tb.sv
// Self-checking testbench for lossy_event_ring_fifo: a ring model predicts the popped
// words, directed and random post/drain streams run under several stall patterns.
// Depends on lerf_pkg and the lossy_event_ring_fifo RTL only.
`timescale 1ns / 1ps

module lossy_event_ring_fifo_tb;
    import lerf_pkg::*;

    localparam int DEPTH       = 16;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_CYCLES = 400;
    localparam int RANDOM_ITEMS_PER_PHASE = 95;

    // One expected output word, field by field
    typedef struct packed {
        logic [BUS_W-1:0]    bus;
        logic [ACTION_W-1:0] action;
        logic [HDEPTH_W-1:0] hub_tier;
        logic [HPORT_W-1:0]  hub_link;
        logic [SLOT_W-1:0]   slot;
        logic [SEQ_W-1:0]    seq;
        logic [STAMP_W-1:0]  stamp_ms;
        logic [DROP_W-1:0]   dropped;
        logic                empty_res;
        logic                last;
    } popped_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [0:0]            s_axis_tuser = CMD_POST;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [0:0]            m_axis_tuser;
    logic                  m_axis_tlast;

    // Ring model state
    entry_t              ring_model [DEPTH];
    int unsigned         ring_head;
    int unsigned         ring_fill;
    logic [SEQ_W-1:0]    seq_next;
    logic [DROP_W-1:0]   drops_pending;
    popped_t             pending_pops [$];

    // Run control and statistics
    int tx_idle_pct;
    int rx_stall_pct;
    bit hold_req;
    int hold_left;
    int cycle_count;
    int n_errors;
    int n_posts;
    int n_drains;
    int n_checked;
    int n_overflows;

    lossy_event_ring_fifo #(
        .RING_DEPTH(DEPTH)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

    always #10 clk = ~clk;

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("cycle limit reached with %0d words outstanding", pending_pops.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    // Receiver: random stalls, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_req)
        begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end

    // Ring model: update state for one accepted word, queue the words it pops
    function automatic void ring_model_accept(input logic cmd,
                                              input logic [IN_DATA_W-1:0] data);
        entry_t      ev;
        popped_t     word;
        int unsigned idx;
        int unsigned limit;
        int unsigned n;
        if (cmd == CMD_POST)
        begin
            ev.bus      = data[7:0];
            ev.action   = data[15:8];
            ev.hub_tier = data[23:16];
            ev.hub_link = data[31:24];
            ev.slot     = data[47:32];
            ev.stamp_ms = data[95:48];
            ev.seq      = seq_next;
            if (ring_fill >= DEPTH)
            begin
                // full: overwrite the oldest entry
                idx           = ring_head;
                ring_head     = (ring_head + 1) % DEPTH;
                drops_pending = drops_pending + 1'b1;
                n_overflows++;
            end
            else
            begin
                idx = (ring_head + ring_fill) % DEPTH;
                ring_fill++;
            end
            ring_model[idx] = ev;
            seq_next = seq_next + 1'b1;
            return;
        end

        limit = 32'(data[100:96]);
        if (limit > 32'(MAX_DRAIN))
            limit = 32'(MAX_DRAIN);
        n = 0;
        while (n < limit && ring_fill > 0)
        begin
            ev              = ring_model[ring_head];
            word.bus        = ev.bus;
            word.action     = ev.action;
            word.hub_tier   = ev.hub_tier;
            word.hub_link   = ev.hub_link;
            word.slot       = ev.slot;
            word.seq        = ev.seq;
            word.stamp_ms   = ev.stamp_ms;
            word.dropped    = (n == 0) ? drops_pending : '0;
            word.empty_res  = 1'b0;
            word.last       = (n + 1 == limit) || (ring_fill == 1);
            pending_pops.push_back(word);
            ring_head = (ring_head + 1) % DEPTH;
            ring_fill--;
            n++;
        end
        if (n == 0)
        begin
            // nothing to pop: one empty word, drop count kept
            word           = '0;
            word.empty_res = 1'b1;
            word.last      = 1'b1;
            pending_pops.push_back(word);
        end
        else
            drops_pending = '0;
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            n_errors++;
        end
    endfunction

    // Check each output word against the oldest expectation
    always @(posedge clk)
    begin : check_results
        popped_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_pops.size() == 0)
            begin
                $error("output word with no expectation pending");
                n_errors++;
            end
            else
            begin
                want = pending_pops.pop_front();
                check_field("out_bus",       64'(want.bus),       64'(m_axis_tdata[7:0]));
                check_field("out_action",    64'(want.action),    64'(m_axis_tdata[15:8]));
                check_field("out_hub_tier",  64'(want.hub_tier),  64'(m_axis_tdata[23:16]));
                check_field("out_hub_link",  64'(want.hub_link),  64'(m_axis_tdata[31:24]));
                check_field("out_slot",      64'(want.slot),      64'(m_axis_tdata[47:32]));
                check_field("event_seq",     64'(want.seq),       64'(m_axis_tdata[95:48]));
                check_field("event_time_ms", 64'(want.stamp_ms),  64'(m_axis_tdata[143:96]));
                check_field("dropped_count", 64'(want.dropped),   64'(m_axis_tdata[159:144]));
                check_field("empty_res",     64'(want.empty_res), 64'(m_axis_tuser[0]));
                check_field("last",          64'(want.last),      64'(m_axis_tlast));
                n_checked++;
            end
        end
    end

    // Send one word; called at a rising edge, returns at a rising edge
    task automatic send_word(input logic cmd, input logic [IN_DATA_W-1:0] data);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tuser  <= cmd;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        ring_model_accept(cmd, data);
        if (cmd == CMD_POST)
            n_posts++;
        else
            n_drains++;
        if ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    task automatic post_event(input logic [7:0] bus, input logic [7:0] action,
                              input logic [7:0] hub_tier, input logic [7:0] hub_link,
                              input logic [15:0] slot, input logic [47:0] now_ms);
        send_word(CMD_POST, {3'b000, 5'($urandom), now_ms, slot, hub_link, hub_tier,
                             action, bus});
    endtask

    task automatic post_random();
        post_event(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                   16'($urandom), 48'({$urandom, $urandom}));
    endtask

    // Device fields of a drain are ignored, so they carry random bits
    task automatic drain_events(input logic [4:0] limit);
        send_word(CMD_DRAIN, {3'b000, limit, $urandom, $urandom, $urandom});
    endtask

    // Stop offering and wait until every expected word has come out
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_pops.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic test_directed();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        drain_events(5'd0);
        drain_events(5'd16);
        post_event(8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, 48'h0);
        post_event(8'hff, 8'hff, 8'hff, 8'hff, 16'hffff, 48'hffff_ffff_ffff);
        drain_events(5'd0);
        drain_events(5'd1);
        drain_events(5'd31);
        // overflow by two, then a saturated drain reports the drops
        repeat (DEPTH + 2) post_random();
        drain_events(5'd17);
        drain_events(5'd3);
        wait_drained();
    endtask

    // Receiver holds off while drains back up into the input
    task automatic test_receiver_hold();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        @(negedge clk);
        hold_req = 1'b1;
        @(posedge clk);
        repeat (DEPTH) post_random();
        repeat (10)
        begin
            drain_events(5'd3);
            repeat (3) post_random();
        end
        wait_drained();
    endtask

    // Bursts of posts closed by a drain, under one stall pattern
    task automatic test_random_phase(input int idle_pct, input int stall_pct);
        int sent;
        int burst;
        tx_idle_pct  = idle_pct;
        rx_stall_pct = stall_pct;
        sent = 0;
        while (sent < RANDOM_ITEMS_PER_PHASE)
        begin
            burst = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2)
                                                : $urandom_range(1, 2 * DEPTH);
            repeat (burst) post_random();
            if ($urandom_range(0, 3) == 0)
                drain_events(5'($urandom_range(0, 31)));
            else
                drain_events(5'($urandom_range(0, 16)));
            sent += burst + 1;
            if ($urandom_range(0, 19) == 0)
                wait_drained();
        end
        wait_drained();
    endtask

    initial
    begin
        ring_head     = 0;
        ring_fill     = 0;
        seq_next      = '0;
        drops_pending = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_receiver_hold();
        test_random_phase(0, 0);
        test_random_phase(63, 0);
        test_random_phase(0, 63);
        test_random_phase(11, 11);

        repeat (10) @(posedge clk);
        if (pending_pops.size() != 0)
        begin
            $error("%0d expected words never came out", pending_pops.size());
            n_errors++;
        end
        $display("Run covered %0d posts (%0d overflowing) and %0d drains;",
                 n_posts, n_overflows, n_drains);
        $display("%0d output words checked, %0d mismatches.", n_checked, n_errors);
        if (n_errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

>>> lossy_event_ring_fifo.f
rtl/lerf_pkg.sv
rtl/lerf_ram.sv
rtl/lerf_ctrl.sv
rtl/lossy_event_ring_fifo.sv
verif/lossy_event_ring_fifo_tb.sv
